@@ hw/rtl/vcb_pkg.sv @@
// ----------------------------------------------------------------------------
// vcb_pkg: shared types and constants of the vertex color blend unit
// Blend mode codes, the result kind of a pixel and the pipeline stage records.
// ----------------------------------------------------------------------------
package vcb_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned ProdW  = 2 * ChanW;
    localparam int unsigned NumRgb = 3;
    localparam int unsigned NumCh  = 4;

    localparam logic [ChanW-1:0] ChanMax = 8'd255;
    localparam logic [ChanW-1:0] SatMax  = 8'd254;

    // Blend mode register codes
    typedef enum logic [2:0] {
        MODE_MIX    = 3'd0,
        MODE_ADD    = 3'd1,
        MODE_SUB    = 3'd2,
        MODE_MUL    = 3'd3,
        MODE_FILTER = 3'd4,
        MODE_PASS_5 = 3'd5,
        MODE_PASS_6 = 3'd6,
        MODE_PASS_7 = 3'd7
    } mode_t;

    // How the result of one item is formed
    typedef enum logic [1:0] {
        KIND_OLD   = 2'd0,
        KIND_PAINT = 2'd1,
        KIND_CALC  = 2'd2
    } kind_t;

    // Stage 1: first products and the pass-through color
    typedef struct packed {
        kind_t                              kind;
        mode_t                              mode;
        logic [NumCh-1:0][ChanW-1:0]        pass_color;
        logic [NumRgb-1:0][ChanW-1:0]       old_c;
        logic [NumRgb-1:0][ProdW-1:0]       sp;
        logic [NumRgb-1:0][ChanW-1:0]       po_hi;
        logic [ChanW-1:0]                   inv;
        logic [ChanW-1:0]                   s;
    } st1_t;

    // Stage 2: second products and the add/subtract results
    typedef struct packed {
        kind_t                              kind;
        mode_t                              mode;
        logic [NumCh-1:0][ChanW-1:0]        pass_color;
        logic [NumRgb-1:0][ProdW-1:0]       io;
        logic [NumRgb-1:0][ProdW-1:0]       spo;
        logic [NumRgb-1:0][ProdW-1:0]       sp;
        logic [NumRgb-1:0][ChanW-1:0]       add_r;
        logic [NumRgb-1:0][ChanW-1:0]       sub_r;
    } st2_t;

endpackage

@@ hw/rtl/vertex_color_blend_unit.sv @@
// ----------------------------------------------------------------------------
// vertex_color_blend_unit: per-pixel RGBA paint blend
// Three-stage pipeline that blends an old color with a paint color.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one item per pixel with the old RGBA color, the
//   paint RGBA color and a strength 0..255, under s_valid / s_ready.
//   Result channel (m_*): one blended RGBA item per input item, in order,
//   under m_valid / m_ready.
//   Configuration: cfg_wr_en writes cfg_wr_data into the blend mode
//   register (0 mix, 1 add, 2 subtract, 3 multiply, 4 filter as mix,
//   5..7 pass). Write it only while no item is in flight.
//   Stages: three register stages (input products, second products, final
//   sum and select); an accepted item passes through them in that order.
//   Throughput: one item per cycle unless a receiver stall has filled every
//   stage; each stage holds at most one item and the 8x8 multipliers of the
//   first two stages set the depth of each stage.
//   Reset (aresetn low, synchronous) empties all stages and sets mode to mix.
//   When the receiver stalls, the result register holds its item and the
//   earlier stages keep filling until every stage is full; only then does
//   s_ready drop. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_color_blend_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_old_red,
    input  logic [7:0] s_old_green,
    input  logic [7:0] s_old_blue,
    input  logic [7:0] s_old_alpha,
    input  logic [7:0] s_paint_red,
    input  logic [7:0] s_paint_green,
    input  logic [7:0] s_paint_blue,
    input  logic [7:0] s_paint_alpha,
    input  logic [7:0] s_strength,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_new_red,
    output logic [7:0] m_new_green,
    output logic [7:0] m_new_blue,
    output logic [7:0] m_new_alpha
);

    // ------------------------------------------------------------------
    // Mode register
    // ------------------------------------------------------------------
    vcb_pkg::mode_t mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= vcb_pkg::MODE_MIX;
        end else if (cfg_wr_en) begin
            mode_reg <= vcb_pkg::mode_t'(cfg_wr_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage load enables. A stage loads when it is
    // empty or its item moves on in the same cycle.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg;
    logic ld1, ld2, ld3;

    assign ld3     = !v3_reg || m_ready;
    assign ld2     = !v2_reg || ld3;
    assign ld1     = !v1_reg || ld2;
    assign s_ready = ld1;
    assign m_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (ld1) v1_reg <= s_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: classify the item and form s*paint, paint*old, 255-s
    // ------------------------------------------------------------------
    vcb_pkg::st1_t st1_reg, st1_next;
    logic [vcb_pkg::NumRgb-1:0][7:0] in_old, in_paint;

    assign in_old   = {s_old_blue, s_old_green, s_old_red};
    assign in_paint = {s_paint_blue, s_paint_green, s_paint_red};

    always_comb begin
        logic [vcb_pkg::ProdW-1:0] po;
        po = '0;
        st1_next.mode = mode_reg;
        st1_next.s    = s_strength;
        st1_next.inv  = vcb_pkg::ChanMax - s_strength;
        if (mode_reg > vcb_pkg::MODE_FILTER || s_strength == '0) begin
            st1_next.kind       = vcb_pkg::KIND_OLD;
            st1_next.pass_color = {s_old_alpha, s_old_blue, s_old_green, s_old_red};
        end else if ((mode_reg == vcb_pkg::MODE_MIX || mode_reg == vcb_pkg::MODE_FILTER)
                     && s_strength == vcb_pkg::ChanMax) begin
            st1_next.kind       = vcb_pkg::KIND_PAINT;
            st1_next.pass_color = {s_paint_alpha, s_paint_blue, s_paint_green,
                                   s_paint_red};
        end else begin
            st1_next.kind       = vcb_pkg::KIND_CALC;
            st1_next.pass_color = {s_old_alpha, s_old_blue, s_old_green, s_old_red};
        end
        for (int c = 0; c < vcb_pkg::NumRgb; c++) begin
            po                 = {8'd0, in_paint[c]} * {8'd0, in_old[c]};
            st1_next.old_c[c]  = in_old[c];
            st1_next.sp[c]     = {8'd0, s_strength} * {8'd0, in_paint[c]};
            st1_next.po_hi[c]  = po[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld1 && s_valid) st1_reg <= st1_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: (255-s)*old, s*((paint*old)>>8), saturating add, clamped sub
    // ------------------------------------------------------------------
    vcb_pkg::st2_t st2_reg, st2_next;

    always_comb begin
        logic [8:0] sum9;
        logic [7:0] d;
        sum9 = '0;
        d    = '0;
        st2_next.kind       = st1_reg.kind;
        st2_next.mode       = st1_reg.mode;
        st2_next.pass_color = st1_reg.pass_color;
        st2_next.sp         = st1_reg.sp;
        for (int c = 0; c < vcb_pkg::NumRgb; c++) begin
            d                  = st1_reg.sp[c][15:8];
            sum9               = {1'b0, st1_reg.old_c[c]} + {1'b0, d};
            st2_next.io[c]     = {8'd0, st1_reg.inv} * {8'd0, st1_reg.old_c[c]};
            st2_next.spo[c]    = {8'd0, st1_reg.s} * {8'd0, st1_reg.po_hi[c]};
            st2_next.add_r[c]  = (sum9 > {1'b0, vcb_pkg::SatMax}) ? vcb_pkg::ChanMax
                                                                  : sum9[7:0];
            st2_next.sub_r[c]  = (d > st1_reg.old_c[c]) ? 8'd0 : st1_reg.old_c[c] - d;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2 && v1_reg) st2_reg <= st2_next;
    end

    // ------------------------------------------------------------------
    // Stage 3: final sums and select into the result register
    // ------------------------------------------------------------------
    logic [vcb_pkg::NumCh-1:0][7:0] res_reg, res_next;

    always_comb begin
        logic [vcb_pkg::ProdW:0] acc;
        acc      = '0;
        res_next = st2_reg.pass_color;
        if (st2_reg.kind == vcb_pkg::KIND_CALC) begin
            res_next[3] = 8'd0;
            for (int c = 0; c < vcb_pkg::NumRgb; c++) begin
                case (st2_reg.mode)
                    vcb_pkg::MODE_ADD: begin
                        res_next[c] = st2_reg.add_r[c];
                    end
                    vcb_pkg::MODE_SUB: begin
                        res_next[c] = st2_reg.sub_r[c];
                    end
                    vcb_pkg::MODE_MUL: begin
                        acc         = {1'b0, st2_reg.io[c]} + {1'b0, st2_reg.spo[c]};
                        res_next[c] = acc[15:8];
                    end
                    default: begin
                        acc         = {1'b0, st2_reg.io[c]} + {1'b0, st2_reg.sp[c]};
                        res_next[c] = acc[15:8];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3 && v2_reg) res_reg <= res_next;
    end

    assign m_new_red   = res_reg[0];
    assign m_new_green = res_reg[1];
    assign m_new_blue  = res_reg[2];
    assign m_new_alpha = res_reg[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("s_ready low while a stage is empty");

    a_mid_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && !ld2) |=> v2_reg)
        else $error("stage 2 item dropped during stall");

    a_calc_alpha_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && ld3 && st2_reg.kind == vcb_pkg::KIND_CALC) |=> (m_new_alpha == 8'd0))
        else $error("computed result carries nonzero alpha");

    a_pass_exact: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && ld3 && st2_reg.kind != vcb_pkg::KIND_CALC)
        |=> (res_reg == $past(st2_reg.pass_color)))
        else $error("pass-through color altered");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the vertex color blend unit
// Drives RGBA pixel items under valid/ready, predicts each blended color in a
// scoreboard and compares every result field. Covers all eight blend modes,
// directed corners first, then random pixels under several idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } rgba_t;

    typedef struct packed {
        rgba_t      old_c;
        rgba_t      paint_c;
        logic [7:0] strength;
    } pixel_t;

    localparam int unsigned NumRandBlocks = 15;
    localparam int unsigned BlockItems    = 50;
    localparam int unsigned DrainCycles   = 6;
    localparam int unsigned StallLimit    = 1000;
    localparam int unsigned ReportMax     = 10;

    // ------------------------------------------------------------------------
    // Scoreboard: holds the blend mode and the queue of expected colors
    // ------------------------------------------------------------------------
    class blend_scoreboard;
        vcb_pkg::mode_t blend_mode;
        rgba_t          expected_colors[$];
        int             mismatches;

        function new();
            blend_mode = vcb_pkg::MODE_MIX;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        function logic [7:0] mix_chan(logic [7:0] o, logic [7:0] p, logic [7:0] s);
            int unsigned ov, pv, sv, t;
            ov = o;
            pv = p;
            sv = s;
            t = ((vcb_pkg::ChanMax - sv) * ov + sv * pv) >> 8;
            return t[7:0];
        endfunction

        function logic [7:0] add_chan(logic [7:0] o, logic [7:0] p, logic [7:0] s);
            int unsigned ov, pv, sv, t;
            ov = o;
            pv = p;
            sv = s;
            t = ov + ((sv * pv) >> 8);
            return (t > vcb_pkg::SatMax) ? vcb_pkg::ChanMax : t[7:0];
        endfunction

        function logic [7:0] sub_chan(logic [7:0] o, logic [7:0] p, logic [7:0] s);
            int unsigned ov, pv, sv, d;
            ov = o;
            pv = p;
            sv = s;
            d = (sv * pv) >> 8;
            return (d > ov) ? 8'd0 : 8'(ov - d);
        endfunction

        function logic [7:0] mul_chan(logic [7:0] o, logic [7:0] p, logic [7:0] s);
            int unsigned ov, pv, sv, t;
            ov = o;
            pv = p;
            sv = s;
            t = ((vcb_pkg::ChanMax - sv) * ov + sv * ((pv * ov) >> 8)) >> 8;
            return t[7:0];
        endfunction

        function logic [7:0] blend_chan(logic [7:0] o, logic [7:0] p, logic [7:0] s);
            case (blend_mode)
                vcb_pkg::MODE_ADD: return add_chan(o, p, s);
                vcb_pkg::MODE_SUB: return sub_chan(o, p, s);
                vcb_pkg::MODE_MUL: return mul_chan(o, p, s);
                default:           return mix_chan(o, p, s);
            endcase
        endfunction

        function rgba_t blend_pixel(pixel_t px);
            rgba_t res;
            bit    mix_like;
            mix_like = (blend_mode == vcb_pkg::MODE_MIX) ||
                       (blend_mode == vcb_pkg::MODE_FILTER);
            if (blend_mode > vcb_pkg::MODE_FILTER || px.strength == 8'd0) begin
                // unknown mode or no strength: old color, old alpha included
                res = px.old_c;
            end else if (mix_like && px.strength == vcb_pkg::ChanMax) begin
                res = px.paint_c;
            end else begin
                res.red   = blend_chan(px.old_c.red,   px.paint_c.red,   px.strength);
                res.green = blend_chan(px.old_c.green, px.paint_c.green, px.strength);
                res.blue  = blend_chan(px.old_c.blue,  px.paint_c.blue,  px.strength);
                res.alpha = 8'd0;
            end
            return res;
        endfunction

        function void note_pixel(pixel_t px);
            expected_colors.push_back(blend_pixel(px));
        endfunction

        function void report_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
            if (exp_v !== got_v) begin
                mismatches++;
                if (mismatches <= ReportMax)
                    $display("%0t: mismatch on %s: expected %0d, got %0d",
                             $realtime, field, exp_v, got_v);
            end
        endfunction

        function void check_pixel(rgba_t got);
            rgba_t exp_c;
            if (expected_colors.size() == 0) begin
                mismatches++;
                if (mismatches <= ReportMax)
                    $display("%0t: result item with no expected color: %h",
                             $realtime, got);
                return;
            end
            exp_c = expected_colors.pop_front();
            report_field("new_red",   exp_c.red,   got.red);
            report_field("new_green", exp_c.green, got.green);
            report_field("new_blue",  exp_c.blue,  got.blue);
            report_field("new_alpha", exp_c.alpha, got.alpha);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [2:0] cfg_wr_data   = 3'd0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_old_red     = 8'd0;
    logic [7:0] s_old_green   = 8'd0;
    logic [7:0] s_old_blue    = 8'd0;
    logic [7:0] s_old_alpha   = 8'd0;
    logic [7:0] s_paint_red   = 8'd0;
    logic [7:0] s_paint_green = 8'd0;
    logic [7:0] s_paint_blue  = 8'd0;
    logic [7:0] s_paint_alpha = 8'd0;
    logic [7:0] s_strength    = 8'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_new_red;
    logic [7:0] m_new_green;
    logic [7:0] m_new_blue;
    logic [7:0] m_new_alpha;

    // percentages of cycles in which each side holds off
    int unsigned send_idle_pct  = 28;
    int unsigned recv_stall_pct = 45;
    int unsigned quiet_cycles   = 0;

    blend_scoreboard sb = new();

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    vertex_color_blend_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_old_red     (s_old_red),
        .s_old_green   (s_old_green),
        .s_old_blue    (s_old_blue),
        .s_old_alpha   (s_old_alpha),
        .s_paint_red   (s_paint_red),
        .s_paint_green (s_paint_green),
        .s_paint_blue  (s_paint_blue),
        .s_paint_alpha (s_paint_alpha),
        .s_strength    (s_strength),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_new_red     (m_new_red),
        .m_new_green   (m_new_green),
        .m_new_blue    (m_new_blue),
        .m_new_alpha   (m_new_alpha)
    );

    // ------------------------------------------------------------------------
    // Result side: sample pre-edge values, check the accepted item, then pick
    // the next ready level
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel({m_new_red, m_new_green, m_new_blue, m_new_alpha});
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic pixel_t make_pixel(rgba_t o, rgba_t p, logic [7:0] s);
        pixel_t px;
        px.old_c    = o;
        px.paint_c  = p;
        px.strength = s;
        return px;
    endfunction

    // Biased byte: extremes show up often, the rest is uniform
    function automatic logic [7:0] pick_chan();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_strength();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15)      return 8'd0;
        else if (r < 30) return 8'd255;
        else if (r < 35) return 8'd1;
        else if (r < 40) return 8'd254;
        else             return 8'($urandom_range(255));
    endfunction

    function automatic pixel_t random_pixel();
        rgba_t o, p;
        o = {pick_chan(), pick_chan(), pick_chan(), pick_chan()};
        p = {pick_chan(), pick_chan(), pick_chan(), pick_chan()};
        return make_pixel(o, p, pick_strength());
    endfunction

    // Called at a rising edge; returns at the edge that accepts the item
    task automatic push_pixel(pixel_t px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_old_red     <= px.old_c.red;
        s_old_green   <= px.old_c.green;
        s_old_blue    <= px.old_c.blue;
        s_old_alpha   <= px.old_c.alpha;
        s_paint_red   <= px.paint_c.red;
        s_paint_green <= px.paint_c.green;
        s_paint_blue  <= px.paint_c.blue;
        s_paint_alpha <= px.paint_c.alpha;
        s_strength    <= px.strength;
        do @(posedge aclk); while (!s_ready);
        sb.note_pixel(px);
    endtask

    // Drop valid, let the pipeline empty, then write the mode register
    task automatic write_mode(vcb_pkg::mode_t mode);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.blend_mode = mode;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        vcb_pkg::mode_t mode;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners, starting in the reset mode (mix)
        push_pixel(make_pixel({8'd10, 8'd20, 8'd30, 8'd40},
                              {8'd200, 8'd210, 8'd220, 8'd230}, 8'd0));   // zero strength
        push_pixel(make_pixel({8'd10, 8'd20, 8'd30, 8'd40},
                              {8'd200, 8'd210, 8'd220, 8'd230}, 8'd255)); // full strength
        push_pixel(make_pixel({8'd255, 8'd255, 8'd255, 8'd255},
                              {8'd0, 8'd0, 8'd0, 8'd0}, 8'd128));
        push_pixel(make_pixel({8'd255, 8'd0, 8'd255, 8'd0},
                              {8'd255, 8'd255, 8'd0, 8'd0}, 8'd1));

        write_mode(vcb_pkg::MODE_ADD);
        push_pixel(make_pixel({8'd200, 8'd255, 8'd0, 8'd9},
                              {8'd255, 8'd255, 8'd255, 8'd255}, 8'd255)); // saturate
        push_pixel(make_pixel({8'd254, 8'd253, 8'd0, 8'd9},
                              {8'd0, 8'd255, 8'd0, 8'd0}, 8'd1));         // just below 255

        write_mode(vcb_pkg::MODE_SUB);
        push_pixel(make_pixel({8'd10, 8'd255, 8'd0, 8'd5},
                              {8'd255, 8'd255, 8'd255, 8'd5}, 8'd255));   // clamp at zero
        push_pixel(make_pixel({8'd10, 8'd255, 8'd0, 8'd5},
                              {8'd255, 8'd255, 8'd255, 8'd5}, 8'd0));

        write_mode(vcb_pkg::MODE_MUL);
        push_pixel(make_pixel({8'd255, 8'd255, 8'd255, 8'd255},
                              {8'd255, 8'd255, 8'd255, 8'd255}, 8'd255));
        push_pixel(make_pixel({8'd128, 8'd64, 8'd0, 8'd1},
                              {8'd255, 8'd128, 8'd77, 8'd1}, 8'd77));

        write_mode(vcb_pkg::MODE_FILTER);
        push_pixel(make_pixel({8'd1, 8'd2, 8'd3, 8'd4},
                              {8'd250, 8'd251, 8'd252, 8'd253}, 8'd255)); // paint returned
        push_pixel(make_pixel({8'd1, 8'd2, 8'd3, 8'd4},
                              {8'd250, 8'd251, 8'd252, 8'd253}, 8'd100));

        // unknown modes pass the old color
        write_mode(vcb_pkg::MODE_PASS_5);
        push_pixel(make_pixel({8'd7, 8'd8, 8'd9, 8'd10},
                              {8'd255, 8'd255, 8'd255, 8'd255}, 8'd128));
        write_mode(vcb_pkg::MODE_PASS_6);
        push_pixel(make_pixel({8'd255, 8'd0, 8'd128, 8'd99},
                              {8'd0, 8'd0, 8'd0, 8'd0}, 8'd255));
        write_mode(vcb_pkg::MODE_PASS_7);
        push_pixel(make_pixel({8'd0, 8'd255, 8'd1, 8'd254},
                              {8'd3, 8'd4, 8'd5, 8'd6}, 8'd200));

        // Random blocks: five per idle pattern, stepping through every mode
        for (int unsigned blk = 0; blk < NumRandBlocks; blk++) begin
            case (blk / 5)
                0: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 45;
                end
                1: begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 28;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            mode = vcb_pkg::mode_t'((blk * 3) % 8);
            write_mode(mode);
            for (int unsigned i = 0; i < BlockItems; i++)
                push_pixel(random_pixel());
        end

        // Drain and let the pipeline settle
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/vcb_pkg.sv
hw/rtl/vertex_color_blend_unit.sv
tb/sv/tb_top.sv
